>>> rtl/fmqd_pkg.sv
// fmqd_pkg: widths, register map, cordic angle table and stage payload type
// for the fm quadrature discriminator; depends on nothing
package fmqd_pkg;

  // signed 16x16 product, sum of two products, cordic x/y and angle widths
  localparam int PROD_W = 32;
  localparam int SUM_W  = 33;
  localparam int XY_W   = 35;
  localparam int Z_W    = 34;
  localparam int ANG_W  = Z_W - 16;
  localparam int GAIN_W = 16;
  localparam int MUL_W  = ANG_W + GAIN_W + 1;
  localparam int ATAN_LEN = 24;

  // register map (index into the register list)
  localparam logic REG_FREQ_GAIN = 1'b0;
  localparam logic [GAIN_W-1:0] FREQ_GAIN_RST = 16'd804;

  // quarter turn in angle units where pi is 2^31
  localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sd1073741824;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
  } cordic_t;

  // atan(2^-k) with pi = 2^31, rounded to nearest
  function automatic logic [31:0] atan_unit(input int k);
    logic [31:0] v;
    case (k)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/fm_quadrature_discriminator.sv
// fm_quadrature_discriminator: polar fm discriminator, conjugate product
// followed by a pipelined cordic atan2 and a q8.8 gain; uses fmqd_pkg and
// fmqd_cordic_stage
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-------------------------------------
//  in_      | in  | in_tvalid/in_tready  | tdata: sample_i[15:0], sample_q[31:16]
//  out_     | out | out_tvalid/out_tready| tdata: freq_out[15:0], tuser: saturated
//  cfg_     | in  | apb psel/penable     | freq_gain at byte address 0
//
// one transaction per cycle sustained while out_tready is held high; the
// cordic chain has one iteration per register stage, CORDIC_STAGES (at most 24)
// rst_n is synchronous: it clears the valid bits, the previous sample and
// the gain register (804); payload registers are not reset
// the whole pipeline advances together whenever the output register is
// empty or being taken, so a stall holds every stage and loses nothing
module fm_quadrature_discriminator
  import fmqd_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // sample_i[15:0], sample_q[31:16]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // freq_out[15:0]
  output logic        out_tuser,   // saturated[0]
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // stages past the tabulated ones do nothing in the algorithm
  localparam int NSTG = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  // ---------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------
  logic [GAIN_W-1:0] gain_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= FREQ_GAIN_RST;
    end else if (cfg_wr && (cfg_paddr[2] == REG_FREQ_GAIN)) begin
      gain_r <= cfg_pwdata[GAIN_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_FREQ_GAIN) ? {16'd0, gain_r} : 32'd0;

  // ---------------------------------------------------------------------
  // flow control: one enable for the whole pipe
  // ---------------------------------------------------------------------
  logic adv;
  logic in_acc;
  logic out_vld_r;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  // ---------------------------------------------------------------------
  // stage 1: previous sample and the four cross products
  // ---------------------------------------------------------------------
  logic signed [15:0] cur_i;
  logic signed [15:0] cur_q;
  logic signed [15:0] prev_i_r;
  logic signed [15:0] prev_q_r;
  logic               p_vld_r;
  logic signed [PROD_W-1:0] p_ii_r;  // cur_i * prev_i
  logic signed [PROD_W-1:0] p_qq_r;  // cur_q * prev_q
  logic signed [PROD_W-1:0] p_qi_r;  // cur_q * prev_i
  logic signed [PROD_W-1:0] p_iq_r;  // cur_i * prev_q

  assign cur_i = in_tdata[15:0];
  assign cur_q = in_tdata[31:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_i_r <= '0;
      prev_q_r <= '0;
      p_vld_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        prev_i_r <= cur_i;
        prev_q_r <= cur_q;
      end
      if (adv) begin
        p_vld_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ii_r <= cur_i * prev_i_r;
      p_qq_r <= cur_q * prev_q_r;
      p_qi_r <= cur_q * prev_i_r;
      p_iq_r <= cur_i * prev_q_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: real and imaginary parts of the conjugate product
  // ---------------------------------------------------------------------
  logic                    s_vld_r;
  logic signed [SUM_W-1:0] re_r;
  logic signed [SUM_W-1:0] im_r;
  logic signed [SUM_W-1:0] re_nxt;
  logic signed [SUM_W-1:0] im_nxt;

  assign re_nxt = {p_ii_r[PROD_W-1], p_ii_r} + {p_qq_r[PROD_W-1], p_qq_r};
  assign im_nxt = {p_qi_r[PROD_W-1], p_qi_r} - {p_iq_r[PROD_W-1], p_iq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (adv) begin
      s_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: quarter-turn pre-rotation into the right half plane
  // ---------------------------------------------------------------------
  logic                   stg_vld [0:NSTG];
  cordic_t                stg_d   [0:NSTG];
  logic                   pre_vld_r;
  cordic_t                pre_d_r;
  cordic_t                pre_nxt;
  logic signed [XY_W-1:0] re_x;
  logic signed [XY_W-1:0] im_x;

  assign re_x = {{(XY_W-SUM_W){re_r[SUM_W-1]}}, re_r};
  assign im_x = {{(XY_W-SUM_W){im_r[SUM_W-1]}}, im_r};

  always_comb begin
    pre_nxt.x    = re_x;
    pre_nxt.y    = im_x;
    pre_nxt.z    = '0;
    pre_nxt.zero = (re_r == '0) && (im_r == '0);
    if (re_r[SUM_W-1]) begin
      if (!im_r[SUM_W-1]) begin
        // upper left: turn by -pi/2
        pre_nxt.x = im_x;
        pre_nxt.y = -re_x;
        pre_nxt.z = QUARTER_TURN;
      end else begin
        // lower left: turn by +pi/2
        pre_nxt.x = -im_x;
        pre_nxt.y = re_x;
        pre_nxt.z = -QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (adv) begin
      pre_vld_r <= s_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_d_r <= pre_nxt;
    end
  end

  assign stg_vld[0] = pre_vld_r;
  assign stg_d[0]   = pre_d_r;

  // ---------------------------------------------------------------------
  // cordic chain: one iteration per register stage
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < NSTG; k++) begin : g_cordic
    fmqd_cordic_stage #(
      .K (k)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_vld  (stg_vld[k]),
      .in_d    (stg_d[k]),
      .out_vld (stg_vld[k+1]),
      .out_d   (stg_d[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // angle stage: round the accumulator to an 18-bit binary angle (pi = 32768)
  // ---------------------------------------------------------------------
  logic                    a_vld_r;
  logic                    a_zero_r;
  logic signed [ANG_W-1:0] ang_r;
  logic signed [Z_W-1:0]   zsum;

  assign zsum = stg_d[NSTG].z + Z_W'(32768);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= stg_vld[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r    <= zsum[Z_W-1:16];
      a_zero_r <= stg_d[NSTG].zero;
    end
  end

  // ---------------------------------------------------------------------
  // gain stage: angle times q8.8 gain
  // ---------------------------------------------------------------------
  logic                    m_vld_r;
  logic                    m_zero_r;
  logic signed [MUL_W-1:0] mul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_r    <= ang_r * $signed({1'b0, gain_r});
      m_zero_r <= a_zero_r;
    end
  end

  // ---------------------------------------------------------------------
  // output stage: round half up, clamp, force zero for a zero product
  // ---------------------------------------------------------------------
  logic signed [MUL_W:0]   rnd;
  logic signed [MUL_W-8:0] scaled;
  logic signed [15:0]      freq_nxt;
  logic                    sat_nxt;
  logic signed [15:0]      out_freq_r;
  logic                    out_sat_r;
  logic                    out_zero_r;

  assign rnd    = {mul_r[MUL_W-1], mul_r} + (MUL_W+1)'(128);
  assign scaled = rnd[MUL_W:8];

  always_comb begin
    freq_nxt = scaled[15:0];
    sat_nxt  = 1'b0;
    if (m_zero_r) begin
      freq_nxt = '0;
    end else if (scaled > (MUL_W-7)'(32767)) begin
      freq_nxt = 16'sh7fff;
      sat_nxt  = 1'b1;
    end else if (scaled < -(MUL_W-7)'(32768)) begin
      freq_nxt = 16'sh8000;
      sat_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_freq_r <= freq_nxt;
      out_sat_r  <= sat_nxt;
      out_zero_r <= m_zero_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_freq_r;
  assign out_tuser  = out_sat_r;

`ifndef SYNTHESIS
  // a clip always lands on one of the two rails
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_sat_r |-> (out_freq_r == 16'sh7fff || out_freq_r == 16'sh8000))
    else $error("saturated flag without rail value");

  // a zero product gives a clean zero result
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_zero_r |-> (out_freq_r == '0 && !out_sat_r))
    else $error("zero product gave nonzero result");

  // the rounded angle stays within a quarter turn plus the summed table steps;
  // tiny vectors near pi can overshoot pi by that much
  a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r |-> (ang_r <= ANG_W'(36864) && ang_r >= -ANG_W'(36864)))
    else $error("cordic angle out of range");

  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && !p_vld_r && !a_vld_r)
    else $error("valid bit survived reset");
`endif

endmodule

>>> rtl/fmqd_cordic_stage.sv
// fmqd_cordic_stage: one registered vectoring iteration of the cordic
// depends on fmqd_pkg (cordic_t, atan_unit)
module fmqd_cordic_stage
  import fmqd_pkg::*;
#(
  parameter int K = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  logic    in_vld,
  input  cordic_t in_d,
  output logic    out_vld,
  output cordic_t out_d
);

  localparam logic signed [Z_W-1:0] ATAN_K = Z_W'(atan_unit(K));

  logic                   vld_r;
  cordic_t                d_r;
  cordic_t                d_nxt;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;

  // arithmetic shift is floor division by 2^K
  assign xs = in_d.x >>> K;
  assign ys = in_d.y >>> K;

  always_comb begin
    d_nxt = in_d;
    if (!in_d.y[XY_W-1]) begin
      d_nxt.x = in_d.x + ys;
      d_nxt.y = in_d.y - xs;
      d_nxt.z = in_d.z + ATAN_K;
    end else begin
      d_nxt.x = in_d.x - ys;
      d_nxt.y = in_d.y + xs;
      d_nxt.z = in_d.z - ATAN_K;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule
